/* rtl/core/wam_pkg.sv */
package wam_pkg;

  localparam int NUM_ALARMS_DEF = 16;
  localparam int ENTRY_IDX_W = 4;
  localparam int ENTRY_CODES = 16;
  localparam logic [6:0] LAST_MINUTE_NONE = 7'd127;

  typedef enum logic [1:0] {
    ACT_TIME  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } act_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] weekday;
    logic [3:0] entry_index;
    logic [4:0] entry_hour;
    logic [5:0] entry_minute;
    logic [6:0] entry_days;
    logic       entry_enable;
    logic [7:0] entry_melody;
    logic [7:0] entry_pulsar;
  } wam_in_t;

  typedef struct packed {
    logic       fired;
    logic [3:0] fired_index;
    logic [7:0] melody;
    logic [7:0] pulsar;
    logic       pending;
    logic [3:0] pending_index;
    logic       any_enabled;
  } wam_out_t;

  // Item travelling down the row of alarm cells, with the running match result.
  typedef struct packed {
    logic       scan;
    logic       write;
    logic       clear;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] weekday;
    logic [3:0] entry_index;
    logic [4:0] entry_hour;
    logic [5:0] entry_minute;
    logic [6:0] entry_days;
    logic       entry_enable;
    logic [7:0] entry_melody;
    logic [7:0] entry_pulsar;
    logic       fired;
    logic [3:0] fired_index;
    logic [7:0] melody;
    logic [7:0] pulsar;
    logic       any_enabled;
  } wam_tok_t;

endpackage

/* rtl/core/weekday_alarm_matcher.sv */
// Alarm table matcher with a weekday mask per entry.
// An item is accepted at a rising edge with start high and busy low. It sets
// a time sample, writes one alarm entry, clears the pending flag, or does nothing.
// Every item produces exactly one result, shown on out_data for one cycle with
// out_valid high; the receiver cannot hold results off.
// The table is a row of NUM_ALARMS cells, one entry per cell. An item walks the
// row one cell per cycle: the addressed cell takes a write, each cell compares a
// time sample with its entry, and every cell adds its enable to any_enabled.
// The result is registered once the item leaves the last cell, and busy falls
// at the same edge, so a new item is accepted only after the previous one has
// walked the whole row, whose length sets how long each item keeps busy high.
// A time sample whose minute equals the previous sample's minute still walks the
// row but does not match.
// Reset disarms every entry, clears the pending flag and index, and forgets the
// last minute, so the first time sample is always compared.
module weekday_alarm_matcher #(
  parameter int NUM_ALARMS = wam_pkg::NUM_ALARMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  wam_pkg::wam_in_t  in_data,
  output logic              out_valid,
  output wam_pkg::wam_out_t out_data
);
  import wam_pkg::*;

  state_t     state_r;
  state_t     state_nxt;
  logic [6:0] last_min_r;
  logic [6:0] last_min_nxt;
  logic       pend_r;
  logic       pend_nxt;
  logic [3:0] pend_idx_r;
  logic [3:0] pend_idx_nxt;
  logic       out_valid_r;
  wam_out_t   out_data_r;
  logic       accept;
  logic       is_time;
  logic       new_min;
  wam_tok_t   tok_in;
  wam_tok_t   tok_end;
  logic       done;

  logic [NUM_ALARMS:0] vld;
  wam_tok_t            tok [NUM_ALARMS+1];

  assign accept  = start && (state_r == ST_IDLE);
  assign is_time = (in_data.action == ACT_TIME);
  assign new_min = ({1'b0, in_data.minute} != last_min_r);

  always_comb begin
    tok_in              = '0;
    tok_in.scan         = is_time && new_min;
    tok_in.write        = (in_data.action == ACT_WRITE);
    tok_in.clear        = (in_data.action == ACT_CLEAR);
    tok_in.hour         = in_data.hour;
    tok_in.minute       = in_data.minute;
    tok_in.weekday      = in_data.weekday;
    tok_in.entry_index  = in_data.entry_index;
    tok_in.entry_hour   = in_data.entry_hour;
    tok_in.entry_minute = in_data.entry_minute;
    tok_in.entry_days   = in_data.entry_days;
    tok_in.entry_enable = in_data.entry_enable;
    tok_in.entry_melody = in_data.entry_melody;
    tok_in.entry_pulsar = in_data.entry_pulsar;
  end

  assign vld[0] = accept;
  assign tok[0] = tok_in;

  for (genvar g = 0; g < NUM_ALARMS; g++) begin : g_cell
    wam_cell #(
      .IDX(g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld[g]),
      .tok_i (tok[g]),
      .vld_o (vld[g+1]),
      .tok_o (tok[g+1])
    );
  end

  assign done    = vld[NUM_ALARMS];
  assign tok_end = tok[NUM_ALARMS];

  always_comb begin
    state_nxt    = state_r;
    last_min_nxt = last_min_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
          if (is_time) begin
            last_min_nxt = {1'b0, in_data.minute};
          end
        end
      end
      ST_SCAN: begin
        if (done) begin
          state_nxt = ST_IDLE;
          if (tok_end.fired) begin
            pend_nxt     = 1'b1;
            pend_idx_nxt = tok_end.fired_index;
          end else if (tok_end.clear) begin
            pend_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_min_r  <= LAST_MINUTE_NONE;
      pend_r      <= 1'b0;
      pend_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_min_r  <= last_min_nxt;
      pend_r      <= pend_nxt;
      pend_idx_r  <= pend_idx_nxt;
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r.fired         <= tok_end.fired;
      out_data_r.fired_index   <= tok_end.fired_index;
      out_data_r.melody        <= tok_end.melody;
      out_data_r.pulsar        <= tok_end.pulsar;
      out_data_r.pending       <= pend_nxt;
      out_data_r.pending_index <= pend_idx_nxt;
      out_data_r.any_enabled   <= tok_end.any_enabled;
    end
  end

  assign busy      = (state_r == ST_SCAN);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(vld))
    else $error("More than one item in the cell row.");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("Accepted item did not make the block busy.");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && !vld[0] == !start)
    else $error("Result shown while an item is still in the row.");
  a_fire_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fired |-> out_data.pending &&
    (out_data.pending_index == out_data.fired_index))
    else $error("A match did not raise the pending flag.");
  a_done_scan: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> state_r == ST_SCAN)
    else $error("Item left the cell row while idle.");
`endif

endmodule

/* rtl/core/wam_cell.sv */
module wam_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  wam_pkg::wam_tok_t tok_i,
  output logic              vld_o,
  output wam_pkg::wam_tok_t tok_o
);
  import wam_pkg::*;

  localparam logic [ENTRY_IDX_W-1:0] CELL_ID = ENTRY_IDX_W'(IDX);
  localparam bit CELL_ADDR = (IDX < ENTRY_CODES);

  logic       en_r;
  logic       en_nxt;
  logic [4:0] hour_r;
  logic [5:0] min_r;
  logic [6:0] days_r;
  logic [7:0] mel_r;
  logic [7:0] pul_r;
  logic       vld_r;
  wam_tok_t   tok_r;
  wam_tok_t   tok_nxt;
  logic       wr_sel;
  logic       hit;
  logic [7:0] days_ext;

  always_comb begin
    wr_sel   = vld_i && tok_i.write && CELL_ADDR && (tok_i.entry_index == CELL_ID);
    en_nxt   = wr_sel ? tok_i.entry_enable : en_r;
    days_ext = {1'b0, days_r};
    hit      = vld_i && tok_i.scan && en_r && (hour_r == tok_i.hour) &&
               (min_r == tok_i.minute) && days_ext[tok_i.weekday];
    tok_nxt  = tok_i;
    if (hit) begin
      tok_nxt.fired       = 1'b1;
      tok_nxt.fired_index = CELL_ID;
      tok_nxt.melody      = mel_r;
      tok_nxt.pulsar      = pul_r;
    end
    tok_nxt.any_enabled = tok_i.any_enabled | en_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r  <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      en_r  <= en_nxt;
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      hour_r <= tok_i.entry_hour;
      min_r  <= tok_i.entry_minute;
      days_r <= tok_i.entry_days;
      mel_r  <= tok_i.entry_melody;
      pul_r  <= tok_i.entry_pulsar;
    end
    tok_r <= tok_nxt;
  end

  assign vld_o = vld_r;
  assign tok_o = tok_r;

endmodule
